// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked concurrent assertion helpers used by the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assert a property on the rising clock edge, disabled while reset is active
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Assert a property on the rising clock edge, also checked through reset
`define ASSERT_CLK_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/pilc_pkg.sv =====
// ----------------------------------------------------------------------------
// pilc_pkg
// Widths, types, register indexes and saturation helpers of the PI integrator
// with lead-lag compensator.
// ----------------------------------------------------------------------------
package pilc_pkg;

    // Field and state widths
    localparam int ERROR_WIDTH = 24;
    localparam int STATE_WIDTH = 32;
    localparam int OUT_W       = 32;
    localparam int COEF_W      = 32;
    localparam int COEF_FRAC   = 30;

    // Stream and configuration port widths
    localparam int S_TDATA_W   = ((ERROR_WIDTH + 7) / 8) * 8;
    localparam int M_TDATA_W   = ((2 * OUT_W + 7) / 8) * 8;
    localparam int CFG_INDEX_W = 2;

    // Multiplier widths: magnitudes, full product, rounded product
    localparam int PROD_W = COEF_W + STATE_WIDTH;
    localparam int MAG_W  = PROD_W + 1 - COEF_FRAC;
    // Accumulator holds the sum of three rounded terms plus sign
    localparam int ACC_W  = MAG_W + 2;

    typedef logic signed [ERROR_WIDTH-1:0] err_t;
    typedef logic signed [STATE_WIDTH-1:0] state_t;
    typedef logic signed [OUT_W-1:0]       out_t;
    typedef logic signed [COEF_W-1:0]      coef_t;
    typedef logic signed [ACC_W-1:0]       acc_t;
    typedef logic [MAG_W-1:0]              mag_t;
    typedef logic [CFG_INDEX_W-1:0]        cfg_index_t;

    // Register indexes
    localparam cfg_index_t REG_INTEGRATOR_GAIN    = 2'd0;
    localparam cfg_index_t REG_LEAD_CURRENT_GAIN  = 2'd1;
    localparam cfg_index_t REG_LEAD_PREVIOUS_GAIN = 2'd2;
    localparam cfg_index_t REG_LEAD_FEEDBACK_GAIN = 2'd3;

    // Reset values of the gains (Q2.30)
    localparam coef_t RST_INTEGRATOR_GAIN    = 32'sd2147484;
    localparam coef_t RST_LEAD_CURRENT_GAIN  = 32'sd34359738;
    localparam coef_t RST_LEAD_PREVIOUS_GAIN = -32'sd837372;
    localparam coef_t RST_LEAD_FEEDBACK_GAIN = 32'sd4256466;

    // Saturation bounds in accumulator width
    localparam acc_t STATE_MAX = acc_t'((64'sd1 <<< (STATE_WIDTH - 1)) - 64'sd1);
    localparam acc_t STATE_MIN = -STATE_MAX - acc_t'(1);
    localparam acc_t OUT_MAX   = acc_t'((64'sd1 <<< (OUT_W - 1)) - 64'sd1);
    localparam acc_t OUT_MIN   = -OUT_MAX - acc_t'(1);

    // Request to the shared multiplier
    typedef struct packed {
        logic   issue;
        coef_t  coef;
        state_t operand;
    } mul_req_t;

    // Rounded magnitude and sign of the last product
    typedef struct packed {
        logic neg;
        mag_t mag;
    } mul_rsp_t;

    // Clamp an accumulator value to the signed state range
    function automatic state_t sat_state(acc_t x);
        acc_t r;
        if (x > STATE_MAX) begin
            r = STATE_MAX;
        end else if (x < STATE_MIN) begin
            r = STATE_MIN;
        end else begin
            r = x;
        end
        return state_t'(r);
    endfunction

    // Clamp a state value to the signed output range
    function automatic out_t sat_out(state_t s);
        acc_t x;
        acc_t r;
        x = acc_t'(s);
        if (x > OUT_MAX) begin
            r = OUT_MAX;
        end else if (x < OUT_MIN) begin
            r = OUT_MIN;
        end else begin
            r = x;
        end
        return out_t'(r);
    endfunction

endpackage

// ===== sv/pi_lead_compensator_unit.sv =====
// ----------------------------------------------------------------------------
// pi_lead_compensator_unit
// Trapezoidal PI integrator followed by a lead-lag section, computed with one
// shared Q2.30 multiplier under a small sequencer.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake             Contents
//  s_*       in         s_tvalid / s_tready   error_sample
//  m_*       out        m_tvalid / m_tready   integrator_out, gate_drive
//  cfg_*     in         cfg_valid / cfg_ready gain register index and value
//
//  A sample is taken in idle; the sequencer then steps through INT, UADD,
//  LEAD1, LEAD2 and LEAD3, and the result is registered as LEAD3 ends. A
//  new sample is taken only back in idle. The shared multiplier issues four
//  products in a row. Reset clears the history, loads the default gains and
//  holds both readies low. If the previous result has not been taken, the
//  last step holds and s_tready stays low until the output register frees.
// ----------------------------------------------------------------------------
module pi_lead_compensator_unit (
    input  logic                               aclk,
    input  logic                               aresetn,
    // stream in
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [pilc_pkg::S_TDATA_W-1:0]     s_tdata,   // [23:0] error_sample
    // stream out
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [pilc_pkg::M_TDATA_W-1:0]     m_tdata,   // [31:0] integrator_out,
                                                          // [63:32] gate_drive
    // configuration
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  pilc_pkg::cfg_index_t               cfg_index,
    input  logic [pilc_pkg::COEF_W-1:0]        cfg_data
);

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_INT   = 6'b000010,
        ST_UADD  = 6'b000100,
        ST_LEAD1 = 6'b001000,
        ST_LEAD2 = 6'b010000,
        ST_LEAD3 = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    pilc_pkg::coef_t  n1_reg, n21_reg, n22_reg, d2_reg;
    pilc_pkg::err_t   err_reg, err_prev_reg;
    pilc_pkg::state_t u_reg, u_prev_reg, v_prev_reg, v_next;
    pilc_pkg::acc_t   acc_reg, base, term, sum;
    pilc_pkg::out_t   out_u_reg, out_v_reg;
    logic             m_tvalid_reg;
    logic             out_free;
    logic             s_fire;
    logic             finish;

    pilc_pkg::mul_req_t mul_req;
    pilc_pkg::mul_rsp_t mul_rsp;

    pilc_mul_unit u_mul (
        .aclk (aclk),
        .req  (mul_req),
        .rsp  (mul_rsp)
    );

    assign cfg_ready = aresetn;
    assign s_tready  = aresetn && (state_reg == ST_IDLE);
    assign s_fire    = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign finish    = (state_reg == ST_LEAD3) && out_free;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = {out_v_reg, out_u_reg};

    // Gain registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            n1_reg  <= pilc_pkg::RST_INTEGRATOR_GAIN;
            n21_reg <= pilc_pkg::RST_LEAD_CURRENT_GAIN;
            n22_reg <= pilc_pkg::RST_LEAD_PREVIOUS_GAIN;
            d2_reg  <= pilc_pkg::RST_LEAD_FEEDBACK_GAIN;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                pilc_pkg::REG_INTEGRATOR_GAIN:    n1_reg  <= cfg_data;
                pilc_pkg::REG_LEAD_CURRENT_GAIN:  n21_reg <= cfg_data;
                pilc_pkg::REG_LEAD_PREVIOUS_GAIN: n22_reg <= cfg_data;
                pilc_pkg::REG_LEAD_FEEDBACK_GAIN: d2_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // Select the product to issue in the INT, UADD, LEAD1 and LEAD2 steps
    always_comb begin
        mul_req.issue   = 1'b0;
        mul_req.coef    = n1_reg;
        mul_req.operand = '0;
        unique case (state_reg)
            ST_INT: begin
                mul_req.issue   = 1'b1;
                mul_req.coef    = n1_reg;
                mul_req.operand = pilc_pkg::state_t'(err_reg)
                                + pilc_pkg::state_t'(err_prev_reg);
            end
            ST_UADD: begin
                mul_req.issue   = 1'b1;
                mul_req.coef    = n22_reg;
                mul_req.operand = u_prev_reg;
            end
            ST_LEAD1: begin
                mul_req.issue   = 1'b1;
                mul_req.coef    = d2_reg;
                mul_req.operand = v_prev_reg;
            end
            ST_LEAD2: begin
                mul_req.issue   = 1'b1;
                mul_req.coef    = n21_reg;
                mul_req.operand = u_reg;
            end
            default: ;
        endcase
    end

    // Accumulate the signed rounded term onto the running base
    always_comb begin
        term = $signed({{(pilc_pkg::ACC_W - pilc_pkg::MAG_W){1'b0}}, mul_rsp.mag});
        unique case (state_reg)
            ST_UADD:  base = pilc_pkg::acc_t'(u_prev_reg);
            ST_LEAD1: base = '0;
            default:  base = acc_reg;
        endcase
        sum    = mul_rsp.neg ? (base - term) : (base + term);
        v_next = pilc_pkg::sat_state(sum);
    end

    // Sequencer
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (s_fire) state_next = ST_INT;
            ST_INT:   state_next = ST_UADD;
            ST_UADD:  state_next = ST_LEAD1;
            ST_LEAD1: state_next = ST_LEAD2;
            ST_LEAD2: state_next = ST_LEAD3;
            ST_LEAD3: if (out_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            err_reg <= s_tdata[pilc_pkg::ERROR_WIDTH-1:0];
        end
        if (state_reg == ST_UADD) begin
            u_reg <= pilc_pkg::sat_state(sum);
        end
        if (state_reg == ST_LEAD1 || state_reg == ST_LEAD2) begin
            acc_reg <= sum;
        end
        if (finish) begin
            out_u_reg <= pilc_pkg::sat_out(u_reg);
            out_v_reg <= pilc_pkg::sat_out(v_next);
        end
    end

    // History, cleared by reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            err_prev_reg <= '0;
            u_prev_reg   <= '0;
            v_prev_reg   <= '0;
        end else if (finish) begin
            err_prev_reg <= err_reg;
            u_prev_reg   <= u_reg;
            v_prev_reg   <= v_next;
        end
    end

    // Output beat valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (finish) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

endmodule

// ===== sv/pilc_mul_unit.sv =====
// ----------------------------------------------------------------------------
// pilc_mul_unit
// Shared sign-magnitude Q2.30 multiplier: registers the full product of a
// coefficient and an operand, then rounds it half away from zero.
// ----------------------------------------------------------------------------
module pilc_mul_unit (
    input  logic               aclk,
    input  pilc_pkg::mul_req_t req,
    output pilc_pkg::mul_rsp_t rsp
);

    logic [pilc_pkg::COEF_W-1:0]      coef_mag;
    logic [pilc_pkg::STATE_WIDTH-1:0] op_mag;
    logic [pilc_pkg::PROD_W-1:0]      prod_next;
    logic [pilc_pkg::PROD_W-1:0]      prod_reg;
    logic                             neg_next;
    logic                             neg_reg;
    logic [pilc_pkg::PROD_W:0]        rounded;

    // Take magnitudes and multiply
    always_comb begin
        coef_mag  = req.coef[pilc_pkg::COEF_W-1] ? (~req.coef + 1'b1) : req.coef;
        op_mag    = req.operand[pilc_pkg::STATE_WIDTH-1] ?
                    (~req.operand + 1'b1) : req.operand;
        neg_next  = req.coef[pilc_pkg::COEF_W-1] ^ req.operand[pilc_pkg::STATE_WIDTH-1];
        prod_next = pilc_pkg::PROD_W'(coef_mag) * pilc_pkg::PROD_W'(op_mag);
    end

    // Hold the product until the next issue
    always_ff @(posedge aclk) begin
        if (req.issue) begin
            prod_reg <= prod_next;
            neg_reg  <= neg_next;
        end
    end

    // Add one half LSB and drop the fraction bits
    always_comb begin
        rounded = ({1'b0, prod_reg} + ((pilc_pkg::PROD_W + 1)'(1) << (pilc_pkg::COEF_FRAC - 1)))
                  >> pilc_pkg::COEF_FRAC;
        rsp.neg = neg_reg;
        rsp.mag = rounded[pilc_pkg::MAG_W-1:0];
    end

endmodule

// ===== sv/pilc_checker.sv =====
// ----------------------------------------------------------------------------
// pilc_checker
// Port-level checks of the compensator: output hold, busy after a sample,
// and reset behavior.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pilc_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [pilc_pkg::M_TDATA_W-1:0] m_tdata
);

    // Stalled output beat holds its value
    `ASSERT_CLK(a_out_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "output beat changed while stalled")

    // A sample keeps the input closed in the INT and UADD steps that follow
    `ASSERT_CLK(a_busy_after_in, aclk, aresetn, s_tvalid && s_tready |=> !s_tready ##1 !s_tready, "input reopened before the sample finished")

    // No result beat is shown right after reset
    `ASSERT_CLK_ALWAYS(a_reset_clears_out, aclk, !aresetn |=> !m_tvalid, "output valid after reset")

endmodule

bind pi_lead_compensator_unit pilc_checker u_pilc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
